// ===== rtl/rbc_pkg.sv =====
// Package for the recurrence byte checksum.
// Holds widths, the recurrence constants and the mod-65535 fold.
// No dependencies.
package rbc_pkg;

  localparam int unsigned TERM_W  = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PROD_W  = 25;  // 9-bit sum times 16-bit term

  typedef logic [TERM_W-1:0] term_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam logic [12:0]       ALPHA_STEP  = 13'd17;
  localparam logic [12:0]       BETA_STEP   = 13'd31;
  localparam logic [8:0]        SEED_OFFSET = 9'd7;
  localparam logic [TERM_W:0]   MODULUS     = 17'd65535;
  localparam logic [TERM_W:0]   TWO_POW_16  = 17'h10000;

  // x mod 65535 for x < 2^25: 2^16 = 1 (mod 65535), so fold high onto low.
  function automatic term_t fold_mod(input prod_t x);
    logic [TERM_W:0] s;
    s = {8'd0, x[PROD_W-1:TERM_W]} + {1'b0, x[TERM_W-1:0]};
    if (s >= MODULUS) begin
      s = s - MODULUS;
    end
    return s[TERM_W-1:0];
  endfunction

endpackage

// ===== rtl/recurrence_byte_checksum_top.sv =====
// Top level of the recurrence byte checksum.
// Holds the input register, the term state and the result register.
// Depends on rbc_pkg and rbc_term.
//
// Usage:
//   Bytes enter on the slave stream (s_tdata = data byte, s_tuser = first
//   byte of a message, s_tlast = last byte). One checksum leaves on the
//   master stream for every byte that carries s_tlast.
//   A transfer takes place when tvalid and tready are both high.
//   Throughput: one byte per cycle unless a last byte stalls (see Stall);
//   the recurrence update (two multiplies, a subtract and a mod-65535 fold)
//   is combinational in the term unit. Path: the checksum of a last byte
//   passes through the input register, then the result register, before
//   it shows on m_tvalid.
//   Stall: while a checksum waits in the result register, non-last bytes
//   keep flowing; a further last byte waits in the input register and
//   s_tready drops until the result is taken.
//   Reset: both terms are 1, the byte index is 0 and both registers empty.
//   A byte without a prior first byte continues from the current state.
module recurrence_byte_checksum_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tuser,   // [0] first_byte
  input  logic                s_tlast,   // last_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata    // [15:0] checksum
);

  logic           in_valid;
  rbc_pkg::byte_t in_byte;
  logic           in_first;
  logic           in_last;

  rbc_pkg::term_t prev_term;
  rbc_pkg::term_t curr_term;
  rbc_pkg::idx_t  byte_index;

  rbc_pkg::term_t curr_term_next;
  rbc_pkg::term_t prev_term_next;
  rbc_pkg::idx_t  byte_index_next;
  rbc_pkg::idx_t  idx_inc;
  rbc_pkg::term_t rec_term;
  logic [8:0]     seed;
  logic           advance;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign idx_inc  = byte_index + rbc_pkg::idx_t'(1);
  assign seed     = {1'b0, in_byte} + rbc_pkg::SEED_OFFSET;

  rbc_term u_term (
    .data_byte (in_byte),
    .idx       (idx_inc),
    .curr_term (curr_term),
    .prev_term (prev_term),
    .next_term (rec_term)
  );

  always_comb begin
    if (in_first) begin
      prev_term_next  = rbc_pkg::term_t'(1);
      curr_term_next  = {7'd0, seed};
      byte_index_next = '0;
    end else begin
      prev_term_next  = curr_term;
      curr_term_next  = rec_term;
      byte_index_next = idx_inc;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
  end

  // recurrence state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_term  <= rbc_pkg::term_t'(1);
      curr_term  <= rbc_pkg::term_t'(1);
      byte_index <= '0;
    end else if (advance) begin
      prev_term  <= prev_term_next;
      curr_term  <= curr_term_next;
      byte_index <= byte_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      m_tdata <= curr_term_next;
    end
  end

endmodule

// ===== rtl/rbc_term.sv =====
// Next-term logic of the recurrence checksum (combinational).
// Forms A and B, subtracts with the 64-bit wrap rule and reduces mod 65535.
// Depends on rbc_pkg.
module rbc_term (
  input  rbc_pkg::byte_t data_byte,
  input  rbc_pkg::idx_t  idx,
  input  rbc_pkg::term_t curr_term,
  input  rbc_pkg::term_t prev_term,
  output rbc_pkg::term_t next_term
);

  logic [12:0]         alpha_full;
  logic [12:0]         beta_full;
  logic [8:0]          coef_a;
  rbc_pkg::prod_t      prod_a;
  rbc_pkg::prod_t      prod_b;
  rbc_pkg::term_t      neg_res;
  logic [16:0]         wrap;

  assign alpha_full = {5'd0, idx} * rbc_pkg::ALPHA_STEP;
  assign beta_full  = {5'd0, idx} * rbc_pkg::BETA_STEP;
  assign coef_a     = {1'b0, data_byte} + {1'b0, alpha_full[7:0]};
  assign prod_a     = {16'd0, coef_a} * {9'd0, curr_term};
  assign prod_b     = {17'd0, beta_full[7:0]} * {9'd0, prev_term};

  always_comb begin
    neg_res = rbc_pkg::fold_mod(prod_b - prod_a);
    // A < B wraps through 2^64, which is 1 mod 65535: result = (1 - m) mod 65535
    wrap = rbc_pkg::TWO_POW_16 - {1'b0, neg_res};
    if (wrap >= rbc_pkg::MODULUS) begin
      wrap = wrap - rbc_pkg::MODULUS;
    end
    if (prod_a >= prod_b) begin
      next_term = rbc_pkg::fold_mod(prod_a - prod_b);
    end else begin
      next_term = wrap[15:0];
    end
  end

endmodule

// ===== tb/sv/tb_recurrence_byte_checksum_top.sv =====
// Self-checking testbench for recurrence_byte_checksum_top.
// Predicts each message checksum from the accepted byte transfers and checks
// the result stream in order. Depends on rbc_pkg and the RTL top level.
module tb_recurrence_byte_checksum_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 5000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    rbc_pkg::byte_t data;
    logic           first;
    logic           last;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] data_byte
  logic        s_tuser = 1'b0;  // [0] first_byte
  logic        s_tlast = 1'b0;  // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [15:0] checksum

  msg_byte_t      pending_bytes[$];
  rbc_pkg::term_t checksum_exp[$];

  // predictor state
  rbc_pkg::term_t prev_t;
  rbc_pkg::term_t curr_t;
  rbc_pkg::idx_t  byte_idx;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int mismatch_cnt;
  int stuck_cnt;
  int queued;

  recurrence_byte_checksum_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Advance the recurrence by one accepted byte; queue a checksum on last.
  task automatic advance_checksum(input msg_byte_t b);
    rbc_pkg::idx_t  i;
    logic [63:0]    alpha;
    logic [63:0]    beta;
    logic [63:0]    a;
    logic [63:0]    bb;
    logic [63:0]    diff;
    rbc_pkg::term_t nt;
    if (b.first) begin
      prev_t   = 16'd1;
      curr_t   = rbc_pkg::term_t'({8'd0, b.data} + 16'd7);
      byte_idx = '0;
    end else begin
      i     = byte_idx + 8'd1;
      alpha = (64'(i) * 64'd17) & 64'hFF;
      beta  = (64'(i) * 64'd31) & 64'hFF;
      a     = (64'(b.data) + alpha) * 64'(curr_t);
      bb    = beta * 64'(prev_t);
      // wraps modulo 2^64 when a < bb, as the recurrence is defined
      diff  = a - bb;
      nt    = rbc_pkg::term_t'(diff % 64'd65535);
      prev_t   = curr_t;
      curr_t   = nt;
      byte_idx = i;
    end
    if (b.last) begin
      checksum_exp.push_back(curr_t);
    end
  endtask

  task automatic queue_byte(input rbc_pkg::byte_t d, input logic f, input logic l);
    msg_byte_t b;
    b.data  = d;
    b.first = f;
    b.last  = l;
    pending_bytes.push_back(b);
    queued++;
  endtask

  // Well-formed message with random content; close = 0 leaves it unterminated.
  task automatic queue_message(input int len, input bit close);
    for (int k = 0; k < len; k++) begin
      queue_byte(rbc_pkg::byte_t'($urandom), k == 0, close && (k == len - 1));
    end
  endtask

  task automatic queue_random_traffic(input int n);
    int kind;
    int len;
    while (queued < n) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      if (kind < 6) begin
        // stray byte continuing whatever state is left over
        queue_byte(rbc_pkg::byte_t'($urandom), 1'b0, $urandom_range(1));
      end else if (kind < 12) begin
        queue_message(len, 1'b0);
      end else begin
        queue_message(len, 1'b1);
      end
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (checksum_exp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender: holds each transfer until accepted, then loads the next byte.
  always @(posedge clk) begin
    msg_byte_t nb;
    if (rst) begin
      prev_t   = 16'd1;
      curr_t   = 16'd1;
      byte_idx = '0;
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_checksum({s_tdata, s_tuser, s_tlast});
      end
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = pending_bytes.pop_front();
          s_tdata  <= nb.data;
          s_tuser  <= nb.first;
          s_tlast  <= nb.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer, drives backpressure.
  always @(posedge clk) begin
    rbc_pkg::term_t want;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (checksum_exp.size() == 0) begin
          flag_mismatch($sformatf("unexpected checksum %0d", m_tdata));
        end else begin
          want = checksum_exp.pop_front();
          if (m_tdata !== want) begin
            flag_mismatch($sformatf("checksum got %0d want %0d", m_tdata, want));
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    stuck_cnt = 0;
    while (stuck_cnt < STUCK_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stuck_cnt = 0;
      end else begin
        stuck_cnt++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    mismatch_cnt  = 0;
    queued        = 0;
    hold_req      = 0;
    hold_seen     = 0;
    send_idle_pct = 9;
    recv_idle_pct = 61;

    // Continuation straight out of reset, from the reset terms.
    queue_byte(8'h5A, 1'b0, 1'b1);
    // One-byte messages at both data extremes.
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1);
    // All-ones and all-zeros messages.
    for (int k = 0; k < 4; k++) queue_byte(8'hFF, k == 0, k == 3);
    for (int k = 0; k < 4; k++) queue_byte(8'h00, k == 0, k == 3);
    // Bytes continuing after a finished message.
    queue_byte(8'h12, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b1);
    // Four-byte message that starts from a large seed byte.
    queue_byte(8'hF0, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b1);
    // Restart in the middle of an open message.
    queue_byte(8'h33, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_random_traffic(PHASE_ITEMS);
    wait_idle();

    // Sender-side idling, then the sender pauses until results drain.
    send_idle_pct = 61;
    recv_idle_pct = 9;
    queue_random_traffic(2 * PHASE_ITEMS);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while short messages keep coming.
    hold_req++;
    for (int k = 0; k < 20; k++) queue_message($urandom_range(1, 3), 1'b1);
    // Index wraps past 255 in this one.
    queue_message(300, 1'b1);
    queue_random_traffic(3 * PHASE_ITEMS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checksum_exp.size() != 0) begin
      flag_mismatch($sformatf("%0d checksums never arrived", checksum_exp.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rbc_pkg.sv
rtl/rbc_term.sv
rtl/recurrence_byte_checksum_top.sv
tb/sv/tb_recurrence_byte_checksum_top.sv
